// ===== design/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder package
// Field widths, command codes and Gregorian month length helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int AMOUNT_WIDTH_DEFAULT = 17;

  localparam int YEAR_W       = 16;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int DATE_W       = YEAR_W + MONTH_W + DAY_W;
  localparam int OUT_TDATA_W  = ((DATE_W + 7) / 8) * 8;
  localparam int LEN_W        = 5;

  typedef enum logic [1:0] {
    CMD_ADD_YEARS  = 2'd0,
    CMD_ADD_MONTHS = 2'd1,
    CMD_ADD_DAYS   = 2'd2
  } cmd_t;

  // residues mod 25 of one hex digit at each position of a 16-bit year
  localparam logic [4:0] MOD25_D3 [16] = '{
    5'd0, 5'd21, 5'd17, 5'd13, 5'd9, 5'd5, 5'd1, 5'd22,
    5'd18, 5'd14, 5'd10, 5'd6, 5'd2, 5'd23, 5'd19, 5'd15
  };
  localparam logic [4:0] MOD25_D2 [16] = '{
    5'd0, 5'd6, 5'd12, 5'd18, 5'd24, 5'd5, 5'd11, 5'd17,
    5'd23, 5'd4, 5'd10, 5'd16, 5'd22, 5'd3, 5'd9, 5'd15
  };
  localparam logic [4:0] MOD25_D1 [16] = '{
    5'd0, 5'd16, 5'd7, 5'd23, 5'd14, 5'd5, 5'd21, 5'd12,
    5'd3, 5'd19, 5'd10, 5'd1, 5'd17, 5'd8, 5'd24, 5'd15
  };

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [6:0] s;
    logic       div25;
    s = 7'(MOD25_D3[y[15:12]]) + 7'(MOD25_D2[y[11:8]])
      + 7'(MOD25_D1[y[7:4]]) + 7'(y[3:0]);
    div25 = (s == 7'd0) || (s == 7'd25) || (s == 7'd50) || (s == 7'd75);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'h0));
  endfunction

  // zero for a month outside 1..12
  function automatic logic [LEN_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                 input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = is_leap(y) ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== design/calendar_date_adder_top.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder
// Adds a signed number of years, months or days to a Gregorian date.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries the command (add years, months, days),
// tdata carries year, month, day and the signed amount. One word is taken
// when the block is idle; it then works on that word alone.
// Output stream m_axis: tdata carries the new year, month and day, tuser the
// status (1 = invalid month or command met, original date returned).
// Add years adds the amount to the year. Add months folds a month that
// leaves 1..12 back by a divide by 12 (quarter, then multiply by the
// reciprocal of 3). Both clamp the day to the new month's length. Add
// days walks the date one month boundary at a time. The next word is
// taken only once the result loads. While a result waits on m_axis_tready
// the next word is still taken and, once done, holds in the sequencer.
// Reset (rst, synchronous) returns the sequencer to idle and drops tvalid.
// ----------------------------------------------------------------------------
module calendar_date_adder_top #(
  parameter int AMOUNT_WIDTH = cda_pkg::AMOUNT_WIDTH_DEFAULT,
  localparam int IN_TDATA_W = ((cda_pkg::DATE_W + AMOUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // year[15:0], month[19:16], day[24:20], amount (signed) above, zero fill
  input  logic [IN_TDATA_W-1:0]          s_axis_tdata,
  // cmd
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // new_year[15:0], new_month[19:16], new_day[24:20], zero fill
  output logic [cda_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic                           m_axis_tuser
);

  localparam int AW = AMOUNT_WIDTH;
  localparam int LW = AMOUNT_WIDTH + 1;
  localparam logic [31:0] DIV3_RECIP = 32'h5555_5556;

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_NORM, ST_DIV, ST_DIVEND, ST_CHECK, ST_WALK, ST_FIN
  } state_t;

  state_t                       state;
  logic [1:0]                   cmd;
  logic [cda_pkg::YEAR_W-1:0]   y0, y;
  logic [cda_pkg::MONTH_W-1:0]  m0, m;
  logic [cda_pkg::DAY_W-1:0]    d0, d;
  logic signed [AW:0]           left;
  logic                         neg;
  logic                         err;
  logic [AW-1:0]                dvd;
  logic [31:0]                  q12;
  logic [3:0]                   rem;
  logic [cda_pkg::YEAR_W-1:0]   new_year;
  logic [cda_pkg::MONTH_W-1:0]  new_month;
  logic [cda_pkg::DAY_W-1:0]    new_day;
  logic                         status;

  logic [cda_pkg::YEAR_W-1:0]   in_year;
  logic [cda_pkg::MONTH_W-1:0]  in_month;
  logic [cda_pkg::DAY_W-1:0]    in_day;
  logic [AW-1:0]                in_amount;

  logic [31:0]                  left_w;
  logic [cda_pkg::LEN_W-1:0]    cur_len;
  logic [cda_pkg::MONTH_W-1:0]  m_dec;
  logic [cda_pkg::YEAR_W-1:0]   y_dec;
  logic [cda_pkg::LEN_W-1:0]    dec_len;
  logic                         fwd;
  logic signed [6:0]            d_s;
  logic signed [6:0]            len_s;
  logic signed [6:0]            step_off;
  logic signed [AW:0]           walk_sum;
  logic [31:0]                  dvd4;
  logic [63:0]                  prod;
  logic [1:0]                   q12_x3;

  assign in_year   = s_axis_tdata[15:0];
  assign in_month  = s_axis_tdata[19:16];
  assign in_day    = s_axis_tdata[24:20];
  assign in_amount = s_axis_tdata[cda_pkg::DATE_W +: AW];

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {7'b0, new_day, new_month, new_year};
  assign m_axis_tuser  = status;

  assign left_w  = 32'(left);
  assign cur_len = cda_pkg::month_len(y, m);
  assign m_dec   = (m <= 4'd1) ? 4'd12 : m - 4'd1;
  assign y_dec   = (m <= 4'd1) ? y - 16'd1 : y;
  assign dec_len = cda_pkg::month_len(y_dec, m_dec);

  // shared adder of the month walk
  assign fwd      = !left[AW];
  assign d_s      = {2'b00, d};
  assign len_s    = {2'b00, cur_len};
  assign step_off = fwd ? d_s - len_s - 7'sd1 : d_s;
  assign walk_sum = left + LW'(step_off);

  // divide by 12: quarter the dividend, then multiply by the reciprocal of 3
  assign dvd4   = 32'(dvd >> 2);
  assign prod   = 64'(dvd4) * 64'(DIV3_RECIP);
  assign q12_x3 = q12[1:0] + {q12[0], 1'b0};
  assign rem    = {dvd4[1:0] - q12_x3, dvd[1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      err           <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd   <= s_axis_tuser;
            y0    <= in_year;
            m0    <= in_month;
            d0    <= in_day;
            y     <= in_year;
            m     <= in_month;
            d     <= in_day;
            left  <= LW'(signed'(in_amount));
            neg   <= in_amount[AW-1];
            err   <= 1'b0;
            state <= ST_START;
          end
        end
        ST_START: begin
          case (cmd)
            cda_pkg::CMD_ADD_YEARS: begin
              y     <= y + left_w[15:0];
              state <= ST_CHECK;
            end
            cda_pkg::CMD_ADD_MONTHS: begin
              left  <= left + LW'(m);
              state <= ST_NORM;
            end
            cda_pkg::CMD_ADD_DAYS: begin
              state <= ST_WALK;
            end
            default: begin
              err   <= 1'b1;
              state <= ST_FIN;
            end
          endcase
        end
        ST_NORM: begin
          if (neg && (left[AW] || left == '0)) begin
            dvd   <= AW'(-left);
            state <= ST_DIV;
          end else if (!neg && left > $signed(LW'(12))) begin
            dvd   <= AW'(left - LW'(1));
            state <= ST_DIV;
          end else begin
            m     <= left[3:0];
            state <= ST_CHECK;
          end
        end
        ST_DIV: begin
          q12   <= prod[63:32];
          state <= ST_DIVEND;
        end
        ST_DIVEND: begin
          if (neg) begin
            y <= y + ~q12[15:0];
            m <= 4'd12 - rem;
          end else begin
            y <= y + q12[15:0];
            m <= rem + 4'd1;
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (cur_len == '0) begin
            err <= 1'b1;
          end else if (d > cur_len) begin
            d <= cur_len;
          end
          state <= ST_FIN;
        end
        ST_WALK: begin
          if (left == '0) begin
            state <= ST_FIN;
          end else if (fwd) begin
            if (cur_len == '0) begin
              err   <= 1'b1;
              state <= ST_FIN;
            end else if (!walk_sum[AW]) begin
              left <= walk_sum;
              d    <= 5'd1;
              if (m == 4'd12) begin
                m <= 4'd1;
                y <= y + 16'd1;
              end else begin
                m <= m + 4'd1;
              end
            end else begin
              d     <= d + left[4:0];
              state <= ST_FIN;
            end
          end else begin
            if (!walk_sum[AW] && walk_sum != '0) begin
              d     <= walk_sum[4:0];
              state <= ST_FIN;
            end else if (dec_len == '0) begin
              err   <= 1'b1;
              state <= ST_FIN;
            end else begin
              m    <= m_dec;
              y    <= y_dec;
              left <= walk_sum;
              d    <= dec_len;
            end
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            new_year      <= err ? y0 : y;
            new_month     <= err ? m0 : m;
            new_day       <= err ? d0 : d;
            status        <= err;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after accept");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_FIN))
    else $error("result raised outside finish step");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVEND) |-> (rem < 4'd12))
    else $error("divide remainder out of range");

  a_walk_direction: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (neg ? (left[AW] || left == '0) : !left[AW]))
    else $error("day walk changed direction");
`endif

endmodule
